// ===== design/tws_pkg.sv =====
// Shared types and constants for the trailing whitespace stripper.
// Used by tws_front, tws_queue, tws_back and the top level; depends on nothing.

package tws_pkg;

   localparam logic [7:0] CH_CR  = 8'h0D;
   localparam logic [7:0] CH_LF  = 8'h0A;
   localparam logic [7:0] CH_SP  = 8'h20;
   localparam logic [7:0] CH_TAB = 8'h09;

   // Depth of the queue between front and back.
   localparam int QUEUE_DEPTH = 2;

   // Command that the front hands to the back for one word.
   typedef enum logic [1:0] {
      CMD_HOLD,     // space or tab: append to the pending run
      CMD_NEWLINE,  // newline: drop the pending run, pass the newline
      CMD_FLUSH     // any other byte, or a last non-newline byte: release run, then pass
   } cmd_type;

   typedef struct packed {
      cmd_type    cmd;
      logic [7:0] data_byte;
      logic       last_byte;
   } entry_type;

endpackage

// ===== design/tws_front.sv =====
// Front end: accepts request words, drops non-final CRs, classifies the rest.
// Depends on tws_pkg.

module tws_front (
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [7:0]            req_data_byte,
   input  logic                  req_last_byte,
   input  logic                  q_full,
   output logic                  q_push,
   output tws_pkg::entry_type    q_entry
);

   logic drop;

   assign req_ready = !q_full;
   // A carriage return that does not end the buffer leaves no trace.
   assign drop   = !req_last_byte && (req_data_byte == tws_pkg::CH_CR);
   assign q_push = req_valid && req_ready && !drop;

   always_comb begin
      q_entry.data_byte = req_data_byte;
      q_entry.last_byte = req_last_byte;
      priority if (req_data_byte == tws_pkg::CH_LF) begin
         q_entry.cmd = tws_pkg::CMD_NEWLINE;
      end else if (!req_last_byte && ((req_data_byte == tws_pkg::CH_SP) ||
                                      (req_data_byte == tws_pkg::CH_TAB))) begin
         q_entry.cmd = tws_pkg::CMD_HOLD;
      end else begin
         q_entry.cmd = tws_pkg::CMD_FLUSH;
      end
   end

endmodule

// ===== design/tws_queue.sv =====
// Short queue of classified words between front and back.
// Depends on tws_pkg.

module tws_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  tws_pkg::entry_type    push_entry,
   output logic                  full,
   input  logic                  pop,
   output logic                  head_valid,
   output tws_pkg::entry_type    head_entry
);

   localparam int PTR_W = (tws_pkg::QUEUE_DEPTH > 1) ? $clog2(tws_pkg::QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(tws_pkg::QUEUE_DEPTH + 1);

   tws_pkg::entry_type slot_ff [tws_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_pop;

   assign full       = (count_ff == CNT_W'(tws_pkg::QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_entry = slot_ff[rd_ptr_ff];
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(tws_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(tws_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push && do_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

// ===== design/tws_back.sv =====
// Back end: keeps the pending whitespace run and emits response words.
// Depends on tws_pkg; fed by tws_queue.

module tws_back #(
   parameter int PENDING_DEPTH = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  q_valid,
   input  tws_pkg::entry_type    q_entry,
   output logic                  q_pop,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [7:0]            rsp_out_byte,
   output logic                  rsp_byte_present,
   output logic                  rsp_run_last,
   output logic                  rsp_stream_end
);

   localparam int CNT_W = $clog2(PENDING_DEPTH + 1);

   logic [PENDING_DEPTH-1:0] kinds_ff, kinds_in;
   logic [CNT_W-1:0]         count_ff, count_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [7:0]               byte_ff, byte_in;
   logic                     present_ff, present_in;
   logic                     run_last_ff, run_last_in;
   logic                     end_ff, end_in;
   logic                     out_free;
   logic                     load;
   logic                     is_tab;
   logic [7:0]               oldest_char;

   assign out_free    = !rsp_valid_ff || rsp_ready;
   assign is_tab      = (q_entry.data_byte == tws_pkg::CH_TAB);
   assign oldest_char = kinds_ff[0] ? tws_pkg::CH_TAB : tws_pkg::CH_SP;

   always_comb begin
      kinds_in    = kinds_ff;
      count_in    = count_ff;
      q_pop       = 1'b0;
      load        = 1'b0;
      byte_in     = byte_ff;
      present_in  = present_ff;
      run_last_in = run_last_ff;
      end_in      = end_ff;
      if (q_valid) begin
         unique case (q_entry.cmd)
            tws_pkg::CMD_HOLD: begin
               if (count_ff == CNT_W'(PENDING_DEPTH)) begin
                  // Run is full: release the oldest entry, append the new one.
                  if (out_free) begin
                     load        = 1'b1;
                     byte_in     = oldest_char;
                     present_in  = 1'b1;
                     run_last_in = 1'b1;
                     end_in      = 1'b0;
                     kinds_in    = kinds_ff >> 1;
                     kinds_in[PENDING_DEPTH-1] = is_tab;
                     q_pop       = 1'b1;
                  end
               end else begin
                  for (int i = 0; i < PENDING_DEPTH; i++) begin
                     if (count_ff == CNT_W'(i)) begin
                        kinds_in[i] = is_tab;
                     end
                  end
                  count_in = count_ff + 1'b1;
                  q_pop    = 1'b1;
               end
            end
            tws_pkg::CMD_NEWLINE: begin
               if (out_free) begin
                  load        = 1'b1;
                  byte_in     = q_entry.data_byte;
                  present_in  = 1'b1;
                  run_last_in = 1'b1;
                  end_in      = q_entry.last_byte;
                  kinds_in    = '0;
                  count_in    = '0;
                  q_pop       = 1'b1;
               end
            end
            tws_pkg::CMD_FLUSH: begin
               if (out_free) begin
                  load = 1'b1;
                  if (count_ff != '0) begin
                     byte_in     = oldest_char;
                     present_in  = 1'b1;
                     run_last_in = 1'b0;
                     end_in      = 1'b0;
                     kinds_in    = kinds_ff >> 1;
                     count_in    = count_ff - 1'b1;
                  end else begin
                     // With no run held the byte is passed; a final carriage return becomes a bare marker.
                     present_in  = (q_entry.data_byte != tws_pkg::CH_CR);
                     byte_in     = present_in ? q_entry.data_byte : 8'h00;
                     run_last_in = 1'b1;
                     end_in      = q_entry.last_byte;
                     kinds_in    = '0;
                     q_pop       = 1'b1;
                  end
               end
            end
            default: begin
            end
         endcase
      end
      rsp_valid_in = load || (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         kinds_ff     <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         kinds_ff     <= kinds_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         byte_ff     <= byte_in;
         present_ff  <= present_in;
         run_last_ff <= run_last_in;
         end_ff      <= end_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_out_byte     = byte_ff;
   assign rsp_byte_present = present_ff;
   assign rsp_run_last     = run_last_ff;
   assign rsp_stream_end   = end_ff;

endmodule

// ===== design/trailing_whitespace_stripper_unit.sv =====
// Top level of the trailing whitespace stripper.
// Depends on tws_pkg, tws_front, tws_queue and tws_back.
//
// Usage:
//  - Request channel (req_valid/req_ready): one text byte per word, with
//    req_last_byte marking the final byte of a buffer.
//  - Response channel (rsp_valid/rsp_ready): one cleaned byte per word.
//    rsp_run_last flags the last word caused by a request word, rsp_stream_end
//    the final word of the buffer; rsp_byte_present is 0 only on the bare end
//    marker left by a final carriage return.
//  - Carriage returns vanish; spaces and tabs are held until a newline drops
//    them or another byte releases them ahead of itself. Once PENDING_DEPTH
//    are held, each new one pushes the oldest out.
//  - Throughput: the front takes one word per cycle while the two-entry queue
//    has room. The back moves a space or tab into the held run and passes a
//    newline straight on; any other byte, the last byte of a buffer included,
//    first releases the held run, one word per entry (0 to PENDING_DEPTH
//    entries); it emits at most one response word per cycle.
//  - Path: a request word is written into the queue, and its first response
//    word is then loaded into the response register if nothing is ahead of it.
//  - A stalled receiver holds the response register; the back then waits and
//    the queue fills, after which req_ready drops.
//  - Reset (synchronous): empties the queue, clears the held run and the
//    response valid.

module trailing_whitespace_stripper_unit #(
   parameter int PENDING_DEPTH = 32
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_data_byte,
   input  logic       req_last_byte,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_byte_present,
   output logic       rsp_run_last,
   output logic       rsp_stream_end
);

   tws_pkg::entry_type push_entry;
   tws_pkg::entry_type head_entry;
   logic               push;
   logic               full;
   logic               pop;
   logic               head_valid;

   // Classify and drop non-final carriage returns.
   tws_front u_front (
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_data_byte (req_data_byte),
      .req_last_byte (req_last_byte),
      .q_full        (full),
      .q_push        (push),
      .q_entry       (push_entry)
   );

   // Decouple the front from the back.
   tws_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .full       (full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_entry (head_entry)
   );

   // Hold the pending run and drive the response register.
   tws_back #(
      .PENDING_DEPTH (PENDING_DEPTH)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .q_valid          (head_valid),
      .q_entry          (head_entry),
      .q_pop            (pop),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_out_byte     (rsp_out_byte),
      .rsp_byte_present (rsp_byte_present),
      .rsp_run_last     (rsp_run_last),
      .rsp_stream_end   (rsp_stream_end)
   );

endmodule

// ===== design/tws_checker.sv =====
// Port-level checks for the trailing whitespace stripper, bound to the top level.
// Depends on tws_pkg and trailing_whitespace_stripper_unit.

module tws_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_out_byte,
   input logic       rsp_byte_present,
   input logic       rsp_run_last,
   input logic       rsp_stream_end
);

   // A stalled response word holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_byte) &&
         $stable(rsp_byte_present) && $stable(rsp_run_last) && $stable(rsp_stream_end))
      else $error("response word changed while stalled");

   // The end of the buffer also ends the run of its request word.
   a_end_is_run_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stream_end |-> rsp_run_last)
      else $error("stream end without run last");

   // A bare marker is empty and closes the buffer.
   a_bare_marker: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_byte_present |-> rsp_stream_end && (rsp_out_byte == 8'h00))
      else $error("malformed end marker");

   // No carriage return ever gets through.
   a_no_cr: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_byte_present |-> rsp_out_byte != tws_pkg::CH_CR)
      else $error("carriage return on response");

   // Response valid is low right after reset.
   a_reset_idle: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind trailing_whitespace_stripper_unit tws_checker u_tws_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_out_byte     (rsp_out_byte),
   .rsp_byte_present (rsp_byte_present),
   .rsp_run_last     (rsp_run_last),
   .rsp_stream_end   (rsp_stream_end)
);

// ===== test/tb_trailing_whitespace_stripper_unit.sv =====
// Testbench for trailing_whitespace_stripper_unit: a table of directed words, then
// random text lines, checked per word against typed words or an internal prediction.
// Depends on tws_pkg and trailing_whitespace_stripper_unit.
`timescale 1ns / 100ps

module tb_trailing_whitespace_stripper_unit;

   localparam int PENDING_DEPTH = 32;
   localparam int RANDOM_WORDS  = 400;
   localparam int CALM_TAIL     = 60;       // last words sent with no idling at all
   localparam int DRAIN_CYCLES  = 16;
   localparam int REPORT_CAP    = 60;       // keep a broken run from flooding the log
   localparam int TIMEOUT_NS    = 2_000_000;
   localparam int NUM_DIRECTED  = 23;

   // One response word as the block should present it.
   typedef struct packed {
      logic [7:0] out_byte;
      logic       byte_present;
      logic       run_last;
      logic       stream_end;
   } clean_word_type;

   // How a directed row is checked: by the predictor, as producing nothing, or
   // against the single word typed into the row.
   typedef enum logic [1:0] {
      CHECK_MODEL,
      CHECK_NONE,
      CHECK_ONE
   } check_kind_type;

   typedef struct packed {
      logic [7:0]     data_byte;
      logic           last_byte;
      check_kind_type chk;
      clean_word_type typed;
   } stim_row_type;

   logic       clock;
   logic       reset;
   logic       req_valid;
   logic       req_ready;
   logic [7:0] req_data_byte;
   logic       req_last_byte;
   logic       rsp_valid;
   logic       rsp_ready;
   logic [7:0] rsp_out_byte;
   logic       rsp_byte_present;
   logic       rsp_run_last;
   logic       rsp_stream_end;

   // Predictor state: the held whitespace run, oldest entry at bit 0, 1 = tab.
   logic [PENDING_DEPTH-1:0] held_kinds;
   int                       held_len;

   clean_word_type cleaned_words_due[$];
   int             error_count;
   bit             idle_on;

   // Directed rows: extremes, every byte class, and the special cases of a
   // dropped carriage return, a final carriage return, trailing whitespace at
   // the end of the buffer, and a final newline that discards the held run.
   stim_row_type directed_rows [NUM_DIRECTED] = '{
      '{8'h41,           1'b0, CHECK_ONE,   '{8'h41, 1'b1, 1'b1, 1'b0}},
      '{8'h00,           1'b0, CHECK_ONE,   '{8'h00, 1'b1, 1'b1, 1'b0}},
      '{8'hFF,           1'b0, CHECK_ONE,   '{8'hFF, 1'b1, 1'b1, 1'b0}},
      '{tws_pkg::CH_CR,  1'b0, CHECK_NONE,  '0},
      '{tws_pkg::CH_LF,  1'b0, CHECK_ONE,   '{tws_pkg::CH_LF, 1'b1, 1'b1, 1'b0}},
      '{tws_pkg::CH_SP,  1'b0, CHECK_NONE,  '0},
      '{tws_pkg::CH_TAB, 1'b0, CHECK_NONE,  '0},
      '{tws_pkg::CH_CR,  1'b0, CHECK_NONE,  '0},
      '{8'h78,           1'b0, CHECK_MODEL, '0},
      '{tws_pkg::CH_SP,  1'b0, CHECK_NONE,  '0},
      '{tws_pkg::CH_TAB, 1'b0, CHECK_NONE,  '0},
      '{tws_pkg::CH_LF,  1'b0, CHECK_ONE,   '{tws_pkg::CH_LF, 1'b1, 1'b1, 1'b0}},
      '{tws_pkg::CH_TAB, 1'b0, CHECK_NONE,  '0},
      '{8'h62,           1'b1, CHECK_MODEL, '0},
      '{tws_pkg::CH_CR,  1'b1, CHECK_ONE,   '{8'h00, 1'b0, 1'b1, 1'b1}},
      '{tws_pkg::CH_SP,  1'b1, CHECK_ONE,   '{tws_pkg::CH_SP, 1'b1, 1'b1, 1'b1}},
      '{tws_pkg::CH_LF,  1'b1, CHECK_ONE,   '{tws_pkg::CH_LF, 1'b1, 1'b1, 1'b1}},
      '{tws_pkg::CH_TAB, 1'b0, CHECK_NONE,  '0},
      '{tws_pkg::CH_CR,  1'b1, CHECK_MODEL, '0},
      '{tws_pkg::CH_SP,  1'b0, CHECK_NONE,  '0},
      '{tws_pkg::CH_LF,  1'b1, CHECK_ONE,   '{tws_pkg::CH_LF, 1'b1, 1'b1, 1'b1}},
      '{8'h80,           1'b1, CHECK_ONE,   '{8'h80, 1'b1, 1'b1, 1'b1}},
      '{8'h7F,           1'b0, CHECK_ONE,   '{8'h7F, 1'b1, 1'b1, 1'b0}}
   };

   trailing_whitespace_stripper_unit #(
      .PENDING_DEPTH(PENDING_DEPTH)
   ) dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_data_byte   (req_data_byte),
      .req_last_byte   (req_last_byte),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_byte_present(rsp_byte_present),
      .rsp_run_last    (rsp_run_last),
      .rsp_stream_end  (rsp_stream_end)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Hard stop in case the block hangs.
   initial begin
      #(TIMEOUT_NS);
      $display("tb_trailing_whitespace_stripper_unit NOT OK");
      $finish;
   end

   // Character for held entry i.
   function automatic logic [7:0] held_char(input int i);
      return held_kinds[i] ? tws_pkg::CH_TAB : tws_pkg::CH_SP;
   endfunction

   // Work out the words that one accepted byte causes, and advance the held run.
   function automatic void predict_cleaned_words(input logic [7:0] b, input logic is_last,
                                                 output clean_word_type words[$]);
      words = {};
      if (is_last) begin
         // A final newline still drops the run; anything else releases it first.
         if (b != tws_pkg::CH_LF) begin
            for (int i = 0; i < held_len; i++)
               words.push_back(clean_word_type'{held_char(i), 1'b1, 1'b0, 1'b0});
         end
         if (b == tws_pkg::CH_CR)
            words.push_back(clean_word_type'{8'h00, 1'b0, 1'b0, 1'b0});
         else
            words.push_back(clean_word_type'{b, 1'b1, 1'b0, 1'b0});
         words[words.size()-1].stream_end = 1'b1;
         held_kinds = '0;
         held_len   = 0;
      end else if (b == tws_pkg::CH_CR) begin
         // drop it
      end else if (b == tws_pkg::CH_SP || b == tws_pkg::CH_TAB) begin
         // A full run pushes its oldest entry out before taking the new one.
         if (held_len >= PENDING_DEPTH) begin
            words.push_back(clean_word_type'{held_char(0), 1'b1, 1'b0, 1'b0});
            held_kinds = held_kinds >> 1;
            held_len--;
         end
         held_kinds[held_len] = (b == tws_pkg::CH_TAB);
         held_len++;
      end else if (b == tws_pkg::CH_LF) begin
         held_kinds = '0;
         held_len   = 0;
         words.push_back(clean_word_type'{b, 1'b1, 1'b0, 1'b0});
      end else begin
         for (int i = 0; i < held_len; i++)
            words.push_back(clean_word_type'{held_char(i), 1'b1, 1'b0, 1'b0});
         held_kinds = '0;
         held_len   = 0;
         words.push_back(clean_word_type'{b, 1'b1, 1'b0, 1'b0});
      end
      if (words.size() > 0)
         words[words.size()-1].run_last = 1'b1;
   endfunction

   // Present one word, hold it until accepted, then queue what it should cause.
   // A random idle burst may follow while idling is on.
   task automatic send_word(input logic [7:0] b, input logic is_last,
                            input check_kind_type chk, input clean_word_type typed);
      clean_word_type words[$];
      req_valid     <= 1'b1;
      req_data_byte <= b;
      req_last_byte <= is_last;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
      predict_cleaned_words(b, is_last, words);
      if (chk == CHECK_MODEL)
         foreach (words[i]) cleaned_words_due.push_back(words[i]);
      else if (chk == CHECK_ONE)
         cleaned_words_due.push_back(typed);
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
   endtask

   // Drop valid and hold off until every queued word has come back.
   task automatic hold_until_drained();
      req_valid <= 1'b0;
      do
         @(posedge clock);
      while (cleaned_words_due.size() != 0);
   endtask

   function automatic void check_field(input string name, input logic [7:0] want,
                                       input logic [7:0] got);
      if (want !== got) begin
         error_count++;
         if (error_count <= REPORT_CAP)
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      end
   endfunction

   // Compare every accepted response word with the oldest one due.
   always @(posedge clock) begin
      clean_word_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (cleaned_words_due.size() == 0) begin
            error_count++;
            if (error_count <= REPORT_CAP)
               $display("%0t: unexpected word, expected none, actual %0h/%0b/%0b/%0b",
                        $time, rsp_out_byte, rsp_byte_present, rsp_run_last,
                        rsp_stream_end);
         end else begin
            want = cleaned_words_due.pop_front();
            check_field("out_byte", want.out_byte, rsp_out_byte);
            check_field("byte_present", 8'(want.byte_present), 8'(rsp_byte_present));
            check_field("run_last", 8'(want.run_last), 8'(rsp_run_last));
            check_field("stream_end", 8'(want.stream_end), 8'(rsp_stream_end));
         end
      end
   end

   // Receiver: ready most of the time, with short stall bursts while idling is on.
   initial begin
      rsp_ready = 1'b0;
      @(posedge clock);
      while (reset)
         @(posedge clock);
      forever begin
         if (idle_on && $urandom_range(0, 5) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
      end
   end

   // Stimulus and end of run.
   initial begin
      int             sent;
      int             seg;
      int             run;
      bit             paused_mid;
      logic [7:0]     b;
      clean_word_type no_word;

      no_word       = '0;
      held_kinds    = '0;
      held_len      = 0;
      error_count   = 0;
      idle_on       = 1'b1;
      paused_mid    = 1'b0;
      sent          = 0;
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_data_byte = 8'h00;
      req_last_byte = 1'b0;

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i])
         send_word(directed_rows[i].data_byte, directed_rows[i].last_byte,
                   directed_rows[i].chk, directed_rows[i].typed);
      hold_until_drained();

      // Random text: mostly words, whitespace runs and line ends, with an
      // occasional overlong run, stray carriage return, raw byte or final byte.
      while (sent < RANDOM_WORDS) begin
         idle_on = (sent < RANDOM_WORDS - CALM_TAIL);
         if (!paused_mid && sent >= RANDOM_WORDS / 2) begin
            hold_until_drained();
            paused_mid = 1'b1;
         end
         seg = $urandom_range(0, 99);
         if (seg < 35) begin
            run = $urandom_range(1, 6);
            repeat (run) begin
               b = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 255))
                                               : 8'($urandom_range(8'h21, 8'h7E));
               send_word(b, 1'b0, CHECK_MODEL, no_word);
            end
            sent += run;
         end else if (seg < 65) begin
            // Now and then run past the held depth so the oldest entry spills.
            run = ($urandom_range(0, 7) == 0) ? $urandom_range(PENDING_DEPTH - 4,
                                                               PENDING_DEPTH + 8)
                                              : $urandom_range(1, 6);
            repeat (run)
               send_word($urandom_range(0, 1) ? tws_pkg::CH_TAB : tws_pkg::CH_SP, 1'b0,
                         CHECK_MODEL, no_word);
            sent += run;
         end else if (seg < 80) begin
            if ($urandom_range(0, 1)) begin
               send_word(tws_pkg::CH_CR, 1'b0, CHECK_MODEL, no_word);
               sent++;
            end
            send_word(tws_pkg::CH_LF, 1'b0, CHECK_MODEL, no_word);
            sent++;
         end else if (seg < 86) begin
            send_word(tws_pkg::CH_CR, 1'b0, CHECK_MODEL, no_word);
            sent++;
         end else if (seg < 93) begin
            send_word(8'($urandom_range(0, 255)), 1'b0, CHECK_MODEL, no_word);
            sent++;
         end else begin
            case ($urandom_range(0, 4))
               0:       b = tws_pkg::CH_CR;
               1:       b = tws_pkg::CH_LF;
               2:       b = tws_pkg::CH_SP;
               3:       b = tws_pkg::CH_TAB;
               default: b = 8'($urandom_range(0, 255));
            endcase
            send_word(b, 1'b1, CHECK_MODEL, no_word);
            sent++;
         end
      end

      req_valid <= 1'b0;
      while (cleaned_words_due.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (error_count == 0)
         $display("tb_trailing_whitespace_stripper_unit OK");
      else
         $display("tb_trailing_whitespace_stripper_unit NOT OK");
      $finish;
   end

endmodule
